// ----- src/playback_position_smoother_assert.svh -----
// Assertion macros used by the playback position smoother checker.
`ifndef PLAYBACK_POSITION_SMOOTHER_ASSERT_SVH
`define PLAYBACK_POSITION_SMOOTHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and decay table of the playback position smoother.
package pps_pkg;

    localparam int EXP_TABLE_BITS = 8;
    localparam int DECAY_STEPS    = EXP_TABLE_BITS + 4;
    localparam int STEP_W         = $clog2(DECAY_STEPS);
    localparam int REM_BITS       = 32 - EXP_TABLE_BITS;
    localparam int PADDR_W        = 4;

    typedef logic signed [63:0] t_q32;

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
    localparam logic [32:0] Q_ONE = 33'h1_0000_0000;

    localparam logic [23:0] RATE_RESET   = 24'd65536;
    localparam logic [31:0] THRESH_RESET = 32'd214748365;

    // exp(-2^k) in Q0.32 for k = 3 down to -12
    localparam logic [31:0] DECAY_TAB [16] = '{
        32'd1440801,    32'd78665070,   32'd581260615,  32'd1580030169,
        32'd2605029347, 32'd3344923893, 32'd3790295335, 32'd4034748382,
        32'd4162825044, 32'd4228380000, 32'd4261543595, 32'd4278222805,
        32'd4286586875, 32'd4290775039, 32'd4292870656, 32'd4293918848
    };

    typedef enum logic [1:0] {
        REG_RATE   = 2'd0,
        REG_PAUSED = 2'd1,
        REG_THRESH = 2'd2
    } t_reg;

    typedef struct packed {
        logic [23:0] rate;
        logic        paused;
        logic [31:0] thresh;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRACK,
        ST_D1,
        ST_ABS,
        ST_HI,
        ST_LO,
        ST_SUM,
        ST_FIN,
        ST_EXTRAP,
        ST_DREF,
        ST_ERR,
        ST_ACC,
        ST_DEC_MUL,
        ST_DEC_RND,
        ST_REM_MUL,
        ST_REM_RND,
        ST_CORR,
        ST_POS,
        ST_EMIT,
        ST_PASS
    } t_state;

    typedef enum logic [1:0] {
        MS_EXTRAP,
        MS_REF,
        MS_ACC,
        MS_VADJ
    } t_ms;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_TRACK,
        OP_D1,
        OP_ABS,
        OP_HI,
        OP_LO,
        OP_SUM,
        OP_FIN,
        OP_EXTRAP,
        OP_DREF,
        OP_ERR,
        OP_ACC,
        OP_DMUL,
        OP_DREM,
        OP_DRND,
        OP_CORR,
        OP_POS,
        OP_EMIT,
        OP_PASS
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              fac_sel;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic [DECAY_STEPS-1:0] dec_bits;
        logic                   rem_nz;
        logic                   out_stall;
    } t_stat;

endpackage

// ----- src/pps_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: one beat carries position, timestamp and vsync adjustment.
interface pps_in_if;
    import pps_pkg::*;

    logic valid;
    logic ready;
    t_q32 position;
    t_q32 timestamp;
    t_q32 vsync_adjust;

    modport source (
        output valid,
        output position,
        output timestamp,
        output vsync_adjust,
        input  ready
    );

    modport sink (
        input  valid,
        input  position,
        input  timestamp,
        input  vsync_adjust,
        output ready
    );
endinterface

// ----- src/pps_out_if.sv -----
`timescale 1ns / 1ps
// Output channel: one beat carries the smoothed position, timestamp and reset flag.
interface pps_out_if;
    import pps_pkg::*;

    logic valid;
    logic ready;
    t_q32 smoothed_position;
    t_q32 adjusted_timestamp;
    logic sync_reset;

    modport source (
        output valid,
        output smoothed_position,
        output adjusted_timestamp,
        output sync_reset,
        input  ready
    );

    modport sink (
        input  valid,
        input  smoothed_position,
        input  adjusted_timestamp,
        input  sync_reset,
        output ready
    );
endinterface

// ----- src/pps_regs.sv -----
`timescale 1ns / 1ps
// APB configuration registers: playback rate, pause and reset threshold.
module pps_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pps_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output pps_pkg::t_cfg                o_cfg
);
    import pps_pkg::*;

    t_cfg r_cfg;
    t_reg reg_sel;
    logic wr_en;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate   <= RATE_RESET;
            r_cfg.paused <= 1'b0;
            r_cfg.thresh <= THRESH_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_RATE:   r_cfg.rate   <= pwdata[23:0];
                REG_PAUSED: r_cfg.paused <= pwdata[0];
                REG_THRESH: r_cfg.thresh <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_RATE:   prdata = {8'd0, r_cfg.rate};
            REG_PAUSED: prdata = {31'd0, r_cfg.paused};
            REG_THRESH: prdata = r_cfg.thresh;
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ----- src/pps_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer that steps the smoother datapath through one item.
module pps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_paused,
    input  pps_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output pps_pkg::t_cmd  o_cmd
);
    import pps_pkg::*;

    t_state            r_state, n_state;
    t_ms               r_ms, n_ms;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              last_step;

    assign last_step = (r_cnt == STEP_W'(DECAY_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ms    <= MS_EXTRAP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ms    <= n_ms;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ms    = r_ms;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_paused ? ST_PASS : ST_TRACK;
                end
            end
            ST_TRACK: n_state = ST_D1;
            ST_D1: begin
                n_state = ST_ABS;
                n_ms    = MS_EXTRAP;
            end
            ST_ABS: n_state = ST_HI;
            ST_HI:  n_state = ST_LO;
            ST_LO:  n_state = ST_SUM;
            ST_SUM: n_state = ST_FIN;
            ST_FIN: begin
                case (r_ms)
                    MS_EXTRAP: n_state = ST_EXTRAP;
                    MS_REF:    n_state = ST_DREF;
                    MS_ACC:    n_state = ST_CORR;
                    default:   n_state = ST_POS;
                endcase
            end
            ST_EXTRAP: begin
                n_state = ST_ABS;
                n_ms    = MS_REF;
            end
            ST_DREF: n_state = ST_ERR;
            ST_ERR:  n_state = ST_ACC;
            ST_ACC: begin
                n_state = ST_DEC_MUL;
                n_cnt   = '0;
            end
            ST_DEC_MUL: begin
                if (i_stat.dec_bits[r_cnt]) begin
                    n_state = ST_DEC_RND;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                    if (last_step) begin
                        n_state = ST_REM_MUL;
                    end
                end
            end
            ST_DEC_RND: begin
                n_cnt   = r_cnt + STEP_W'(1);
                n_state = last_step ? ST_REM_MUL : ST_DEC_MUL;
            end
            ST_REM_MUL: begin
                if (i_stat.rem_nz) begin
                    n_state = ST_REM_RND;
                end else begin
                    n_state = ST_ABS;
                    n_ms    = MS_ACC;
                end
            end
            ST_REM_RND: begin
                n_state = ST_ABS;
                n_ms    = MS_ACC;
            end
            ST_CORR: begin
                n_state = ST_ABS;
                n_ms    = MS_VADJ;
            end
            ST_POS: n_state = ST_EMIT;
            ST_EMIT, ST_PASS: begin
                if (!i_stat.out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        o_cmd.fac_sel = (r_ms == MS_ACC);
        o_cmd.step    = r_cnt;
        case (r_state)
            ST_IDLE:    o_cmd.op = i_in_valid ? OP_LOAD : OP_NOP;
            ST_TRACK:   o_cmd.op = OP_TRACK;
            ST_D1:      o_cmd.op = OP_D1;
            ST_ABS:     o_cmd.op = OP_ABS;
            ST_HI:      o_cmd.op = OP_HI;
            ST_LO:      o_cmd.op = OP_LO;
            ST_SUM:     o_cmd.op = OP_SUM;
            ST_FIN:     o_cmd.op = OP_FIN;
            ST_EXTRAP:  o_cmd.op = OP_EXTRAP;
            ST_DREF:    o_cmd.op = OP_DREF;
            ST_ERR:     o_cmd.op = OP_ERR;
            ST_ACC:     o_cmd.op = OP_ACC;
            ST_DEC_MUL: o_cmd.op = i_stat.dec_bits[r_cnt] ? OP_DMUL : OP_NOP;
            ST_DEC_RND: o_cmd.op = OP_DRND;
            ST_REM_MUL: o_cmd.op = i_stat.rem_nz ? OP_DREM : OP_NOP;
            ST_REM_RND: o_cmd.op = OP_DRND;
            ST_CORR:    o_cmd.op = OP_CORR;
            ST_POS:     o_cmd.op = OP_POS;
            ST_EMIT:    o_cmd.op = i_stat.out_stall ? OP_NOP : OP_EMIT;
            ST_PASS:    o_cmd.op = i_stat.out_stall ? OP_NOP : OP_PASS;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

endmodule

// ----- src/pps_dpath.sv -----
`timescale 1ns / 1ps
// Smoother datapath: filter state, shared 32x33 multiplier, saturating adders, output register.
module pps_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pps_pkg::t_cmd   i_cmd,
    input  pps_pkg::t_cfg   i_cfg,
    input  pps_pkg::t_q32   i_position,
    input  pps_pkg::t_q32   i_timestamp,
    input  pps_pkg::t_q32   i_vsync_adjust,
    input  logic            i_out_ready,
    output pps_pkg::t_stat  o_stat,
    output logic            o_out_valid,
    output pps_pkg::t_q32   o_smoothed_position,
    output pps_pkg::t_q32   o_adjusted_timestamp,
    output logic            o_sync_reset
);
    import pps_pkg::*;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? Q_MIN : Q_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        if ((a[63] != b[63]) && (d[63] != a[63])) begin
            return a[63] ? Q_MIN : Q_MAX;
        end
        return d;
    endfunction

    // filter state
    logic [63:0] r_last_time, r_change_time, r_change_pos;
    logic [63:0] r_ref_time, r_ref_pos, r_err_acc;

    // item and scratch
    logic [63:0] r_pos, r_tm, r_vadj;
    logic [63:0] r_dt, r_x, r_mag, r_hi, r_prod, r_res;
    logic [63:0] r_extrap, r_t, r_err, r_corr;
    logic        r_neg, r_sync, r_fix;
    logic [32:0] r_fac;

    // output register
    logic        r_out_valid, r_out_sync;
    logic [63:0] r_out_pos, r_out_ts;

    logic [32:0] mul_k;
    logic [31:0] mul_a;
    logic [32:0] mul_b;
    logic [64:0] mul_p;
    logic [32:0] rem_k;
    logic [63:0] abs_x, sum_mag, fin_val, rnd;
    logic        sum_ovf, over;

    assign mul_k = i_cmd.fac_sel ? r_fac : {9'd0, i_cfg.rate};
    assign rem_k = Q_ONE - 33'(r_dt[REM_BITS-1:0]);

    always_comb begin
        case (i_cmd.op)
            OP_HI: begin
                mul_a = r_mag[63:32];
                mul_b = mul_k;
            end
            OP_DMUL: begin
                mul_a = DECAY_TAB[4'(i_cmd.step)];
                mul_b = r_fac;
            end
            OP_DREM: begin
                mul_a = rem_k[31:0];
                mul_b = r_fac;
            end
            default: begin
                mul_a = r_mag[31:0];
                mul_b = mul_k;
            end
        endcase
    end

    assign mul_p = {33'd0, mul_a} * {32'd0, mul_b};

    assign abs_x = r_x[63] ? (64'd0 - r_x) : r_x;

    always_comb begin
        if (i_cmd.fac_sel) begin
            sum_ovf = r_hi[63];
            sum_mag = r_hi + {32'd0, r_prod[63:32]};
        end else begin
            sum_ovf = |r_hi[63:47];
            sum_mag = {r_hi[47:0], 16'd0} + {16'd0, r_prod[63:16]};
        end
    end

    always_comb begin
        if (r_neg) begin
            fin_val = r_mag[63] ? Q_MIN : (64'd0 - r_mag);
        end else begin
            fin_val = r_mag[63] ? Q_MAX : r_mag;
        end
    end

    assign rnd  = r_prod + 64'h0000_0000_8000_0000;
    assign over = (r_mag > {32'd0, i_cfg.thresh});

    always_comb begin
        for (int k = 0; k < DECAY_STEPS; k++) begin
            o_stat.dec_bits[k] = ~r_fix & r_dt[35-k];
        end
        o_stat.rem_nz    = ~r_fix & (|r_dt[REM_BITS-1:0]);
        o_stat.out_stall = r_out_valid & ~i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= '0;
            r_change_time <= '0;
            r_change_pos  <= '0;
            r_ref_time    <= '0;
            r_ref_pos     <= '0;
            r_err_acc     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if ((i_cmd.op == OP_EMIT) || (i_cmd.op == OP_PASS)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_TRACK: begin
                    r_last_time <= r_tm;
                    if (r_change_pos != r_pos) begin
                        r_change_time <= r_tm;
                        r_change_pos  <= r_pos;
                    end
                end
                OP_CORR: begin
                    if (over) begin
                        r_err_acc  <= '0;
                        r_ref_time <= r_change_time;
                        r_ref_pos  <= r_change_pos;
                    end else begin
                        r_err_acc <= sat_sub(r_res, r_err);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_pos  <= i_position;
                r_tm   <= i_timestamp;
                r_vadj <= i_vsync_adjust;
            end
            OP_TRACK: r_dt <= sat_sub(r_tm, r_last_time);
            OP_D1:    r_x  <= sat_sub(r_tm, r_change_time);
            OP_ABS: begin
                r_neg <= r_x[63];
                r_mag <= abs_x;
            end
            OP_HI:  r_hi   <= mul_p[63:0];
            OP_LO:  r_prod <= mul_p[63:0];
            OP_SUM: r_mag  <= sum_ovf ? Q_MIN : sum_mag;
            OP_FIN: r_res  <= fin_val;
            OP_EXTRAP: begin
                r_extrap <= sat_add(r_pos, r_res);
                r_x      <= sat_sub(r_tm, r_ref_time);
            end
            OP_DREF: r_t   <= sat_sub(r_extrap, r_ref_pos);
            OP_ERR:  r_err <= sat_sub(r_res, r_t);
            OP_ACC: begin
                r_x <= sat_add(r_err_acc, r_err);
                if (r_dt[63] || (r_dt == 64'd0)) begin
                    r_fac <= Q_ONE;
                    r_fix <= 1'b1;
                end else if (|r_dt[62:36]) begin
                    r_fac <= '0;
                    r_fix <= 1'b1;
                end else begin
                    r_fac <= Q_ONE;
                    r_fix <= 1'b0;
                end
            end
            OP_DMUL, OP_DREM: r_prod <= mul_p[63:0];
            OP_DRND: r_fac <= {1'b0, rnd[63:32]};
            OP_CORR: begin
                r_x    <= r_vadj;
                r_sync <= over;
                r_corr <= over ? 64'd0 : r_res;
            end
            OP_POS: r_t <= sat_add(r_extrap, r_corr);
            OP_EMIT: begin
                r_out_pos  <= sat_add(r_t, r_res);
                r_out_ts   <= sat_add(r_tm, r_vadj);
                r_out_sync <= r_sync;
            end
            OP_PASS: begin
                r_out_pos  <= r_pos;
                r_out_ts   <= r_tm;
                r_out_sync <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid          = r_out_valid;
    assign o_smoothed_position  = r_out_pos;
    assign o_adjusted_timestamp = r_out_ts;
    assign o_sync_reset         = r_out_sync;

endmodule

// ----- src/playback_position_smoother.sv -----
`timescale 1ns / 1ps
// Top level of the playback position smoother.
//
// i_in takes one beat per displayed frame: coarse position, wall-clock timestamp
// and vsync adjustment, all signed Q32.32 seconds. o_out returns one beat per
// input beat: smoothed position, adjusted timestamp and the sync_reset flag.
// The APB port sets playback rate (0x0), pause (0x4) and reset threshold (0x8);
// pready is always high and writes land on the access cycle.
// One item is worked at a time by a sequencer over a single 32x33 multiplier.
// When running, the sequencer adds a multiply and a rounding step for each set bit
// among the 12 table bits of the elapsed time (none when it is negative, zero or
// 16 s and above) and one pair more when the low 24 remainder bits are nonzero;
// the input is ready again in the cycle after the result is registered. When
// paused the beat goes through the pass state straight to the output register.
// A finished result waits in the output register, and the input takes the next
// beat meanwhile; that next result holds until the receiver takes the first.
// Reset clears the filter state and restores the register defaults.
module playback_position_smoother (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pps_in_if.sink                       i_in,
    pps_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pps_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import pps_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    pps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_paused   (cfg.paused),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    pps_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_cfg                (cfg),
        .i_position           (i_in.position),
        .i_timestamp          (i_in.timestamp),
        .i_vsync_adjust       (i_in.vsync_adjust),
        .i_out_ready          (o_out.ready),
        .o_stat               (stat),
        .o_out_valid          (o_out.valid),
        .o_smoothed_position  (o_out.smoothed_position),
        .o_adjusted_timestamp (o_out.adjusted_timestamp),
        .o_sync_reset         (o_out.sync_reset)
    );

    assign i_in.ready = in_ready;

endmodule

// ----- src/pps_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the playback position smoother and their bind.
`include "playback_position_smoother_assert.svh"

module pps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    `PPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_rst_n && i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")

    `PPS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_rst_n && i_in_valid && i_in_ready, !i_in_ready, "input taken while an item is in work")

    `PPS_ASSERT_SAME(a_out_from_work, i_clk, i_rst_n, i_rst_n && $rose(i_out_valid), !$past(i_in_ready), "result appeared without an item in work")

endmodule

bind playback_position_smoother pps_checker u_pps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
